### sv/stpp_pkg.sv
`default_nettype none
package stpp_pkg;

  localparam int unsigned PID_W = 23;
  localparam logic [PID_W-1:0] PID_LIMIT = 23'd4194304;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_WS    = 3'b001,
    PH_TOKEN = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic             ident_present;
    logic [10:0]      ident_offset;
    logic [11:0]      ident_length;
    logic [PID_W-1:0] pid_value;
    logic [11:0]      consumed_length;
  } out_beat_t;

endpackage
`default_nettype wire

### sv/syslog_tag_pid_parser.sv
`default_nettype none
// Channel  Direction  Payload               Handshake
// in_      input      stpp_pkg::in_beat_t   in_valid / in_ready
// out_     output     stpp_pkg::out_beat_t  out_valid / out_ready
// cfg_     input      max_ident_len, 12 bit cfg_we, no wait
//
// The block takes one byte beat per clock while in_ready is high. The scan state
// is registered on each accepted beat; on the final beat the result is formed from
// the next-state values and loaded into the output register, so out_valid rises in
// the cycle after acceptance. in_ready falls only while a result waits in the output
// register and out_ready is low. Synchronous reset clears the scan state, the output
// valid flag and sets max_ident_len to 255.
module syslog_tag_pid_parser #(
  parameter int unsigned MAX_MSG_LEN = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire stpp_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output stpp_pkg::out_beat_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [11:0]         cfg_wdata
);

  // Positions run from 0 up to MAX_MSG_LEN inclusive.
  localparam int unsigned POS_W = $clog2(MAX_MSG_LEN + 1);
  // Working width for results: wide enough for the output fields and a position plus one.
  localparam int unsigned W = (POS_W + 1 > 12) ? POS_W + 1 : 12;
  localparam int unsigned PW = stpp_pkg::PID_W;

  logic [11:0]          max_len_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  stpp_pkg::phase_t     phase_r, phase_nxt;
  logic [POS_W-1:0]     tok_start_r, tok_start_nxt;
  logic [POS_W-1:0]     tok_end_r, tok_end_nxt;
  logic [POS_W-1:0]     obr_pos_r, obr_pos_nxt;
  logic                 brk_seen_r, brk_seen_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic                 dig_ok_r, dig_ok_nxt;
  logic [PW-1:0]        pid_close_r, pid_close_nxt;
  logic                 pid_ok_close_r, pid_ok_close_nxt;
  logic [15:0]          prev_r, prev_nxt;
  logic                 sep_r, sep_nxt;

  logic                 out_valid_r;
  stpp_pkg::out_beat_t  out_data_r;
  stpp_pkg::out_beat_t  result;

  logic                 accept;
  logic                 pos_ok;
  logic                 is_space;
  logic [7:0]           b;
  logic [PW-1:0]        acc_step;
  logic                 acc_ovf;

  // Values at the end of the message, used only to form the result.
  logic [POS_W-1:0]     fin_end;
  logic [POS_W-1:0]     tlen;
  logic [POS_W-1:0]     id_len;
  logic                 found;

  assign b        = in_data.data_byte;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pos_ok   = (pos_r < POS_W'(MAX_MSG_LEN)) && (phase_r != stpp_pkg::PH_DONE);
  assign is_space = (b == stpp_pkg::CHAR_SP) || (b == stpp_pkg::CHAR_TAB) ||
                    (b == stpp_pkg::CHAR_LF) || (b == stpp_pkg::CHAR_CR);

  stpp_pid_digit u_digit (
    .acc      (acc_r),
    .digit    (4'(b - stpp_pkg::CHAR_ZERO)),
    .acc_nxt  (acc_step),
    .overflow (acc_ovf)
  );

  // Per-byte scan: whitespace skip, token collection and bracketed PID tracking.
  always_comb begin
    pos_nxt          = pos_r;
    phase_nxt        = phase_r;
    tok_start_nxt    = tok_start_r;
    tok_end_nxt      = tok_end_r;
    obr_pos_nxt      = obr_pos_r;
    brk_seen_nxt     = brk_seen_r;
    acc_nxt          = acc_r;
    dig_ok_nxt       = dig_ok_r;
    pid_close_nxt    = pid_close_r;
    pid_ok_close_nxt = pid_ok_close_r;
    prev_nxt         = prev_r;
    sep_nxt          = sep_r;

    if (accept && pos_ok) begin
      if (b == stpp_pkg::CHAR_NUL) begin
        // A NUL byte ends the text; it is not taken as a separator.
        if (phase_r == stpp_pkg::PH_TOKEN) begin
          tok_end_nxt = pos_r;
        end
        phase_nxt = stpp_pkg::PH_DONE;
      end else if (is_space) begin
        if (phase_r == stpp_pkg::PH_TOKEN) begin
          tok_end_nxt = pos_r;
          sep_nxt     = 1'b1;
          phase_nxt   = stpp_pkg::PH_DONE;
        end
      end else begin
        if (phase_r == stpp_pkg::PH_WS) begin
          phase_nxt     = stpp_pkg::PH_TOKEN;
          tok_start_nxt = pos_r;
          prev_nxt      = 16'h0000;
          brk_seen_nxt  = 1'b0;
        end
        prev_nxt = {prev_nxt[7:0], b};
        if (b == stpp_pkg::CHAR_OPEN) begin
          brk_seen_nxt = 1'b1;
          obr_pos_nxt  = pos_r;
          acc_nxt      = '0;
          dig_ok_nxt   = 1'b1;
        end else if (b == stpp_pkg::CHAR_CLOSE) begin
          pid_close_nxt    = acc_r;
          pid_ok_close_nxt = dig_ok_r;
          dig_ok_nxt       = 1'b0;
        end else if (b >= stpp_pkg::CHAR_ZERO && b <= stpp_pkg::CHAR_NINE) begin
          if (dig_ok_r) begin
            acc_nxt = acc_step;
            if (acc_ovf) begin
              dig_ok_nxt = 1'b0;
            end
          end
        end else begin
          dig_ok_nxt = 1'b0;
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    // A token still open at the final byte ends just after the current byte.
    fin_end = (phase_nxt == stpp_pkg::PH_TOKEN) ? pos_nxt : tok_end_nxt;
  end

  // Result of the message from the state after its final byte.
  always_comb begin
    tlen   = fin_end - tok_start_nxt;
    id_len = tlen - POS_W'(1);
    found  = (fin_end > tok_start_nxt) && (prev_nxt[7:0] == stpp_pkg::CHAR_COLON);
    result = '0;
    if (found) begin
      result.found = 1'b1;
      if (id_len != '0 && prev_nxt[15:8] == stpp_pkg::CHAR_CLOSE && brk_seen_nxt) begin
        // The bracketed PID is cut off the identifier.
        id_len = obr_pos_nxt - tok_start_nxt;
        if (pid_ok_close_nxt && pid_close_nxt != '0 &&
            pid_close_nxt <= stpp_pkg::PID_LIMIT) begin
          result.pid_value = pid_close_nxt;
        end
      end
      if (W'(id_len) <= W'(max_len_r)) begin
        result.ident_present = 1'b1;
        result.ident_offset  = 11'(W'(tok_start_nxt));
        result.ident_length  = 12'(W'(id_len));
      end
      result.consumed_length = 12'(W'(fin_end) + W'(sep_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 12'd255;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // Scan state returns to its reset value after every final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.is_last)) begin
      pos_r          <= '0;
      phase_r        <= stpp_pkg::PH_WS;
      tok_start_r    <= '0;
      tok_end_r      <= '0;
      obr_pos_r      <= '0;
      brk_seen_r     <= 1'b0;
      acc_r          <= '0;
      dig_ok_r       <= 1'b0;
      pid_close_r    <= '0;
      pid_ok_close_r <= 1'b0;
      prev_r         <= '0;
      sep_r          <= 1'b0;
    end else begin
      pos_r          <= pos_nxt;
      phase_r        <= phase_nxt;
      tok_start_r    <= tok_start_nxt;
      tok_end_r      <= tok_end_nxt;
      obr_pos_r      <= obr_pos_nxt;
      brk_seen_r     <= brk_seen_nxt;
      acc_r          <= acc_nxt;
      dig_ok_r       <= dig_ok_nxt;
      pid_close_r    <= pid_close_nxt;
      pid_ok_close_r <= pid_ok_close_nxt;
      prev_r         <= prev_nxt;
      sep_r          <= sep_nxt;
    end
  end

  // Output register: holds a result beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_data.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.is_last) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sv/stpp_pid_digit.sv
`default_nettype none
// One decimal digit step of the PID accumulator, saturating just above the limit.
module stpp_pid_digit (
  input  wire logic [stpp_pkg::PID_W-1:0] acc,
  input  wire logic [3:0]                 digit,
  output logic      [stpp_pkg::PID_W-1:0] acc_nxt,
  output logic                            overflow
);

  localparam int unsigned PROD_W = stpp_pkg::PID_W + 4;

  logic [PROD_W-1:0] prod;

  // acc * 10 as (acc << 3) + (acc << 1), plus the digit.
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + PROD_W'(digit);
  assign overflow = prod > PROD_W'(stpp_pkg::PID_LIMIT);
  assign acc_nxt = overflow ? (stpp_pkg::PID_LIMIT + stpp_pkg::PID_W'(1))
                            : prod[stpp_pkg::PID_W-1:0];

endmodule
`default_nettype wire
